@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside of reset
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/deq_pkg.sv @@
// types and constants of the deadline event queue
package deq_pkg;

  localparam int ID_W  = 32;
  localparam int DL_W  = 32;
  localparam int PR_W  = 4;
  localparam int REG_W = 32;
  localparam int IDX_W = 2;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_REMOVE = 2'd1;
  localparam func_t FUNC_CHECK  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_NONE_DUE  = 2'd3;

  typedef logic [1:0] action_t;
  localparam action_t ACT_NONE    = 2'd0;
  localparam action_t ACT_DISCARD = 2'd1;
  localparam action_t ACT_EXECUTE = 2'd2;

  typedef logic [IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_EXPIRY_WINDOW   = 2'd0;
  localparam reg_idx_t REG_EXEMPT_PRIORITY = 2'd1;

  localparam logic [REG_W-1:0] EXPIRY_WINDOW_RST   = 32'd1800;
  localparam logic [PR_W-1:0]  EXEMPT_PRIORITY_RST = 4'd10;

  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [PR_W-1:0] priority_lvl;
    logic [ID_W-1:0] id;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

@@ rtl/core/deq_in_if.sv @@
// request channel of the deadline event queue
interface deq_in_if;
  logic                       valid;
  logic                       ready;
  deq_pkg::func_t             func;
  logic [deq_pkg::DL_W-1:0]   deadline;
  logic [deq_pkg::PR_W-1:0]   priority_req;
  logic [deq_pkg::ID_W-1:0]   target_id;
  logic [deq_pkg::DL_W-1:0]   now_time;

  modport source (output valid, func, deadline, priority_req, target_id, now_time,
                  input ready);
  modport sink (input valid, func, deadline, priority_req, target_id, now_time,
                output ready);
endinterface

@@ rtl/core/deq_out_if.sv @@
// result channel of the deadline event queue
interface deq_out_if #(
  parameter int CNT_W = 5
);
  logic                       valid;
  logic                       ready;
  deq_pkg::status_t           status;
  deq_pkg::action_t           action;
  logic [deq_pkg::ID_W-1:0]   evt_id;
  logic [deq_pkg::DL_W-1:0]   event_deadline;
  logic [deq_pkg::PR_W-1:0]   evt_prio;
  logic [CNT_W-1:0]           occupancy;

  modport source (output valid, status, action, evt_id, event_deadline,
                  evt_prio, occupancy, input ready);
  modport sink (input valid, status, action, evt_id, event_deadline,
                evt_prio, occupancy, output ready);
endinterface

@@ rtl/core/deq_cfg_if.sv @@
// register write channel of the deadline event queue
interface deq_cfg_if;
  logic                        valid;
  logic                        ready;
  deq_pkg::reg_idx_t           index;
  logic [deq_pkg::REG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/deq_ram.sv @@
// generic simple dual port ram with registered read
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/deadline_event_queue.sv @@
// deadline event queue: sorted slot memory with a scanning sequencer
//
// Requests come in on in_ch (insert, remove by id, check for a due event),
// one result per request leaves on out_ch, and the two registers (expiry
// window, exempt priority) are written through the always ready cfg_ch,
// by the user only while idle; not enforced. All channels use valid/ready.
// Slots live in one memory, ordered from latest deadline at slot 0 to the
// earliest at the top of the fill count. A request is worked on alone and
// walks the memory through its single read port, one slot per cycle:
//   insert: scan down and shift up, then write
//   remove: scan up, shifting down after the match
//   check:  read the earliest slot
// A refused insert, an unused code and a remove or check on an empty queue
// go straight to the finish state, an empty-queue insert to the write.
// The result register frees the sequencer: the next request is taken while
// a result waits; a finished request holds in its last state until the
// result register is free. Reset empties the queue, restarts ids at zero
// and restores the register defaults; the slot memory is not cleared, as
// only slots below the fill count are ever read.
module deadline_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch,
  deq_cfg_if.sink    cfg_ch
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INS    = 7'b0000010,
    S_WNEW   = 7'b0000100,
    S_REM    = 7'b0001000,
    S_CHK_RD = 7'b0010000,
    S_CHK_EV = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [deq_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic [deq_pkg::REG_W-1:0]   window_r;
  logic [deq_pkg::PR_W-1:0]    exempt_r;

  // request operands
  logic [deq_pkg::DL_W-1:0]    dl_r, dl_nxt;
  logic [deq_pkg::PR_W-1:0]    pr_r, pr_nxt;
  logic [deq_pkg::ID_W-1:0]    tid_r, tid_nxt;
  logic [deq_pkg::DL_W-1:0]    now_r, now_nxt;

  // scan control
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  logic                        rd_more_r, rd_more_nxt;
  logic                        ev_vld_r, ev_vld_nxt;
  logic [AW-1:0]               ev_idx_r, ev_idx_nxt;
  logic                        found_r, found_nxt;
  logic [AW-1:0]               wpos_r, wpos_nxt;

  // pending result
  deq_pkg::status_t            res_status_r, res_status_nxt;
  deq_pkg::action_t            res_action_r, res_action_nxt;
  logic [deq_pkg::ID_W-1:0]    res_id_r, res_id_nxt;
  logic [deq_pkg::DL_W-1:0]    res_dl_r, res_dl_nxt;
  logic [deq_pkg::PR_W-1:0]    res_pr_r, res_pr_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  deq_pkg::status_t            out_status_r, out_status_nxt;
  deq_pkg::action_t            out_action_r, out_action_nxt;
  logic [deq_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic [deq_pkg::DL_W-1:0]    out_dl_r, out_dl_nxt;
  logic [deq_pkg::PR_W-1:0]    out_pr_r, out_pr_nxt;
  logic [CW-1:0]               out_occ_r, out_occ_nxt;

  // memory port
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  deq_pkg::slot_t              ram_wslot;
  logic [deq_pkg::SLOT_W-1:0]  ram_rdata;
  deq_pkg::slot_t              rd_slot;

  logic                        in_fire;
  logic                        cfg_fire;
  logic [AW-1:0]               last_idx;
  logic [deq_pkg::DL_W-1:0]    late_by;
  logic                        id_match;
  logic [CW-1:0]               cnt_p1;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  assign rd_slot  = deq_pkg::slot_t'(ram_rdata);
  assign last_idx = AW'(cnt_r - CW'(1));
  assign late_by  = now_r - rd_slot.deadline;
  assign id_match = (rd_slot.id == tid_r);
  assign cnt_p1   = cnt_r + CW'(1);

  deq_ram #(
    .WIDTH (deq_pkg::SLOT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    next_id_nxt    = next_id_r;
    dl_nxt         = dl_r;
    pr_nxt         = pr_r;
    tid_nxt        = tid_r;
    now_nxt        = now_r;
    rd_idx_nxt     = rd_idx_r;
    rd_more_nxt    = rd_more_r;
    ev_vld_nxt     = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    found_nxt      = found_r;
    wpos_nxt       = wpos_r;
    res_status_nxt = res_status_r;
    res_action_nxt = res_action_r;
    res_id_nxt     = res_id_r;
    res_dl_nxt     = res_dl_r;
    res_pr_nxt     = res_pr_r;
    ram_we         = 1'b0;
    ram_waddr      = ev_idx_r;
    ram_wslot      = rd_slot;

    // read issue shared by both scans
    if ((state_r == S_INS || state_r == S_REM) && rd_more_r) begin
      ev_vld_nxt = 1'b1;
      ev_idx_nxt = rd_idx_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dl_nxt         = in_ch.deadline;
          pr_nxt         = in_ch.priority_req;
          tid_nxt        = in_ch.target_id;
          now_nxt        = in_ch.now_time;
          res_status_nxt = deq_pkg::ST_OK;
          res_action_nxt = deq_pkg::ACT_NONE;
          res_id_nxt     = '0;
          res_dl_nxt     = '0;
          res_pr_nxt     = '0;
          found_nxt      = 1'b0;
          rd_more_nxt    = 1'b1;
          case (in_ch.func)
            deq_pkg::FUNC_INSERT: begin
              if (cnt_r == CW'(QUEUE_DEPTH)) begin
                res_status_nxt = deq_pkg::ST_FULL;
                state_nxt      = S_FIN;
              end else if (cnt_r == '0) begin
                wpos_nxt  = '0;
                state_nxt = S_WNEW;
              end else begin
                rd_idx_nxt = last_idx;
                state_nxt  = S_INS;
              end
            end
            deq_pkg::FUNC_REMOVE: begin
              if (cnt_r == '0) begin
                res_status_nxt = deq_pkg::ST_NOT_FOUND;
                state_nxt      = S_FIN;
              end else begin
                rd_idx_nxt = '0;
                state_nxt  = S_REM;
              end
            end
            deq_pkg::FUNC_CHECK: begin
              if (cnt_r == '0) begin
                res_status_nxt = deq_pkg::ST_NONE_DUE;
                state_nxt      = S_FIN;
              end else begin
                rd_idx_nxt = last_idx;
                state_nxt  = S_CHK_RD;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_INS: begin
        // walk down from the earliest slot, moving earlier-deadline ones up
        if (rd_more_r) begin
          if (rd_idx_r == '0) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r - AW'(1);
          end
        end
        if (ev_vld_r) begin
          if (rd_slot.deadline >= dl_r) begin
            wpos_nxt   = ev_idx_r + AW'(1);
            ev_vld_nxt = 1'b0;
            state_nxt  = S_WNEW;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ev_idx_r + AW'(1);
            if (ev_idx_r == '0) begin
              wpos_nxt   = '0;
              ev_vld_nxt = 1'b0;
              state_nxt  = S_WNEW;
            end
          end
        end
      end

      S_WNEW: begin
        ram_we                 = 1'b1;
        ram_waddr              = wpos_r;
        ram_wslot.deadline     = dl_r;
        ram_wslot.priority_lvl = pr_r;
        ram_wslot.id           = next_id_r;
        res_id_nxt             = next_id_r;
        next_id_nxt            = next_id_r + deq_pkg::ID_W'(1);
        cnt_nxt                = cnt_r + CW'(1);
        state_nxt              = S_FIN;
      end

      S_REM: begin
        // walk up from slot 0; after the first match every slot moves down
        if (rd_more_r) begin
          if (rd_idx_r == last_idx) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
        if (ev_vld_r) begin
          if (found_r) begin
            ram_we    = 1'b1;
            ram_waddr = ev_idx_r - AW'(1);
          end else if (id_match) begin
            found_nxt = 1'b1;
          end
          if (ev_idx_r == last_idx) begin
            ev_vld_nxt = 1'b0;
            state_nxt  = S_FIN;
            if (found_r || id_match) begin
              cnt_nxt    = cnt_r - CW'(1);
              res_id_nxt = tid_r;
            end else begin
              res_status_nxt = deq_pkg::ST_NOT_FOUND;
            end
          end
        end
      end

      S_CHK_RD: begin
        state_nxt = S_CHK_EV;
      end

      S_CHK_EV: begin
        state_nxt = S_FIN;
        if (now_r < rd_slot.deadline) begin
          res_status_nxt = deq_pkg::ST_NONE_DUE;
        end else begin
          res_id_nxt = rd_slot.id;
          res_dl_nxt = rd_slot.deadline;
          res_pr_nxt = rd_slot.priority_lvl;
          cnt_nxt    = cnt_r - CW'(1);
          if (late_by > window_r && rd_slot.priority_lvl < exempt_r) begin
            res_action_nxt = deq_pkg::ACT_DISCARD;
          end else begin
            res_action_nxt = deq_pkg::ACT_EXECUTE;
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_action_nxt = out_action_r;
    out_id_nxt     = out_id_r;
    out_dl_nxt     = out_dl_r;
    out_pr_nxt     = out_pr_r;
    out_occ_nxt    = out_occ_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_action_nxt = res_action_r;
      out_id_nxt     = res_id_r;
      out_dl_nxt     = res_dl_r;
      out_pr_nxt     = res_pr_r;
      out_occ_nxt    = cnt_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.action         = out_action_r;
  assign out_ch.evt_id         = out_id_r;
  assign out_ch.event_deadline = out_dl_r;
  assign out_ch.evt_prio       = out_pr_r;
  assign out_ch.occupancy      = out_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      next_id_r   <= '0;
      window_r    <= deq_pkg::EXPIRY_WINDOW_RST;
      exempt_r    <= deq_pkg::EXEMPT_PRIORITY_RST;
      rd_more_r   <= 1'b0;
      ev_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      next_id_r   <= next_id_nxt;
      rd_more_r   <= rd_more_nxt;
      ev_vld_r    <= ev_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_ch.index)
          deq_pkg::REG_EXPIRY_WINDOW:   window_r <= cfg_ch.data;
          deq_pkg::REG_EXEMPT_PRIORITY: exempt_r <= cfg_ch.data[deq_pkg::PR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_r         <= dl_nxt;
    pr_r         <= pr_nxt;
    tid_r        <= tid_nxt;
    now_r        <= now_nxt;
    rd_idx_r     <= rd_idx_nxt;
    ev_idx_r     <= ev_idx_nxt;
    wpos_r       <= wpos_nxt;
    res_status_r <= res_status_nxt;
    res_action_r <= res_action_nxt;
    res_id_r     <= res_id_nxt;
    res_dl_r     <= res_dl_nxt;
    res_pr_r     <= res_pr_nxt;
    out_status_r <= out_status_nxt;
    out_action_r <= out_action_nxt;
    out_id_r     <= out_id_nxt;
    out_dl_r     <= out_dl_nxt;
    out_pr_r     <= out_pr_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  `DEQ_ASSERT(a_cnt_bound, cnt_r <= CW'(QUEUE_DEPTH), "fill count above queue depth")
  `DEQ_ASSERT(a_id_ins, $changed(next_id_r) |-> cnt_r == $past(cnt_p1), "id without insert")
  `DEQ_ASSERT_ALWAYS(a_no_idle_write, ram_we |-> state_r != S_IDLE, "slot write while idle")

endmodule

@@ dv/deq_checker.sv @@
// scoreboard for the deadline event queue: models the sorted slots and compares every result
module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  deq_in_if    req_mon,
  deq_out_if   rsp_mon,
  deq_cfg_if   reg_mon,
  output int   fail_count,
  output int   pending,
  output int   n_requests,
  output int   n_executed,
  output int   n_discarded,
  output int   n_refused,
  output int   n_unknown,
  output int   n_none_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t         status;
    action_t         action;
    logic [ID_W-1:0] evt_id;
    logic [DL_W-1:0] event_deadline;
    logic [PR_W-1:0] evt_prio;
    logic [4:0]      occupancy;
  } outcome_t;

  // slot 0 holds the latest deadline, slot fill-1 the earliest
  slot_t            slots[DEPTH];
  int               fill;
  logic [ID_W-1:0]  id_next;
  logic [REG_W-1:0] window;
  logic [PR_W-1:0]  exempt;
  outcome_t         answers_owed[$];
  outcome_t         want;
  outcome_t         owed;
  int errs, reqs, execs, discards, refusals, unknowns, idles;

  function automatic outcome_t apply_request(func_t op, logic [DL_W-1:0] dl,
                                             logic [PR_W-1:0] pr, logic [ID_W-1:0] tid,
                                             logic [DL_W-1:0] now_t);
    outcome_t res;
    int pos;
    int i;
    res = '0;
    case (op)
      FUNC_INSERT: begin
        if (fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new entry goes behind every deadline greater or equal
          pos = 0;
          while (pos < fill && slots[pos].deadline >= dl) pos++;
          for (i = fill; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = '{deadline: dl, priority_lvl: pr, id: id_next};
          res.evt_id = id_next;
          id_next++;
          fill++;
        end
      end
      FUNC_REMOVE: begin
        pos = fill;
        for (i = 0; i < fill; i++) begin
          if (slots[i].id == tid) begin
            pos = i;
            break;
          end
        end
        if (pos < fill) begin
          for (i = pos; i < fill - 1; i++) slots[i] = slots[i+1];
          fill--;
          res.evt_id = tid;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      FUNC_CHECK: begin
        if (fill == 0 || now_t < slots[fill-1].deadline) begin
          res.status = ST_NONE_DUE;
        end else begin
          pos = fill - 1;
          res.evt_id         = slots[pos].id;
          res.event_deadline = slots[pos].deadline;
          res.evt_prio       = slots[pos].priority_lvl;
          if (now_t - slots[pos].deadline > window && slots[pos].priority_lvl < exempt)
            res.action = ACT_DISCARD;
          else
            res.action = ACT_EXECUTE;
          fill--;
        end
      end
      default: ;
    endcase
    res.occupancy = 5'(fill);
    return res;
  endfunction

  function automatic void match_field(string name, logic [31:0] exp_val, logic [31:0] got);
    if (got !== exp_val) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill    = 0;
      id_next = '0;
      window  = EXPIRY_WINDOW_RST;
      exempt  = EXEMPT_PRIORITY_RST;
      answers_owed.delete();
    end else begin
      if (reg_mon.valid && reg_mon.ready) begin
        if (reg_mon.index == REG_EXPIRY_WINDOW)
          window = reg_mon.data;
        else if (reg_mon.index == REG_EXEMPT_PRIORITY)
          exempt = reg_mon.data[PR_W-1:0];
      end
      // a result always belongs to an earlier request, so compare before queuing
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (answers_owed.size() == 0) begin
          $display("%0t: result with id %0h arrived with no request outstanding",
                   $time, rsp_mon.evt_id);
          errs++;
        end else begin
          want = answers_owed.pop_front();
          match_field("status", 32'(want.status), 32'(rsp_mon.status));
          match_field("action", 32'(want.action), 32'(rsp_mon.action));
          match_field("evt_id", want.evt_id, rsp_mon.evt_id);
          match_field("event_deadline", want.event_deadline, rsp_mon.event_deadline);
          match_field("evt_prio", 32'(want.evt_prio), 32'(rsp_mon.evt_prio));
          match_field("occupancy", 32'(want.occupancy), 32'(rsp_mon.occupancy));
          if (want.action == ACT_EXECUTE) execs++;
          if (want.action == ACT_DISCARD) discards++;
          if (want.status == ST_FULL) refusals++;
          if (want.status == ST_NOT_FOUND) unknowns++;
          if (want.status == ST_NONE_DUE) idles++;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        owed = apply_request(req_mon.func, req_mon.deadline,
                             req_mon.priority_req, req_mon.target_id,
                             req_mon.now_time);
        answers_owed = {answers_owed, owed};
        reqs++;
      end
    end
    fail_count  <= errs;
    pending     <= answers_owed.size();
    n_requests  <= reqs;
    n_executed  <= execs;
    n_discarded <= discards;
    n_refused   <= refusals;
    n_unknown   <= unknowns;
    n_none_due  <= idles;
  end

endmodule

@@ dv/testbench.sv @@
// top of the deadline event queue testbench: clock, reset, stimulus, flow control and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int    DEPTH         = 16;
  localparam int    QUIET_LIMIT   = 4000;
  localparam int    SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int    HOLD_CYCLES   = 300;
  localparam int    PHASE_ITEMS   = 120;
  localparam int    NUM_PHASES    = 6;
  localparam func_t FUNC_UNUSED   = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  deq_in_if  in_ch();
  deq_out_if out_ch();
  deq_cfg_if cfg_ch();

  int fail_count, pending, n_requests, n_executed, n_discarded;
  int n_refused, n_unknown, n_none_due;

  int send_idle, recv_stall, hold_asked, hold_served, hold_left, quiet;
  int inserts_sent, ph, k, ins_pct;
  logic [DL_W-1:0]  time_base;
  logic [REG_W-1:0] win_val;
  logic [PR_W-1:0]  exm_val;

  deadline_event_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deq_checker #(.DEPTH(DEPTH)) result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_ch),
    .rsp_mon     (out_ch),
    .reg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_requests  (n_requests),
    .n_executed  (n_executed),
    .n_discarded (n_discarded),
    .n_refused   (n_refused),
    .n_unknown   (n_unknown),
    .n_none_due  (n_none_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_served  <= hold_served + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_req(func_t op, logic [DL_W-1:0] dl, logic [PR_W-1:0] pr,
                          logic [ID_W-1:0] tid, logic [DL_W-1:0] now_t);
    while ($urandom_range(99, 0) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= op;
    in_ch.deadline     <= dl;
    in_ch.priority_req <= pr;
    in_ch.target_id    <= tid;
    in_ch.now_time     <= now_t;
    if (op == FUNC_INSERT) inserts_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait until every result is back, then let the sequencer go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [REG_W-1:0] win, logic [PR_W-1:0] exm);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_EXPIRY_WINDOW;
    cfg_ch.data  <= win;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_EXEMPT_PRIORITY;
    cfg_ch.data  <= REG_W'(exm);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_req(int insert_pct);
    int pick;
    func_t op;
    logic [DL_W-1:0] dl;
    logic [DL_W-1:0] now_t;
    logic [ID_W-1:0] tid;
    pick = $urandom_range(99, 0);
    if (pick < 3) op = FUNC_UNUSED;
    else if (pick < 3 + insert_pct) op = FUNC_INSERT;
    else if (pick < 16 + insert_pct) op = FUNC_REMOVE;
    else op = FUNC_CHECK;
    time_base += $urandom_range(30, 0);
    pick = $urandom_range(99, 0);
    if (pick < 4) dl = $urandom();
    else if (pick < 6) dl = '1;
    else if (pick < 8) dl = '0;
    else if (pick < 22) dl = (time_base / 1000) * 1000 + 100 * $urandom_range(3, 1);  // ties
    else dl = time_base + $urandom_range(3000, 0);
    pick = $urandom_range(99, 0);
    if (pick < 5) now_t = $urandom();
    else if (pick < 7) now_t = '1;
    else if (pick < 8) now_t = '0;
    else now_t = time_base + $urandom_range(6000, 0);
    // mostly recent ids so removes tend to hit
    if (inserts_sent > 0 && $urandom_range(99, 0) < 75)
      tid = ID_W'(inserts_sent) - $urandom_range(24, 1);
    else
      tid = $urandom();
    send_req(op, dl, PR_W'($urandom_range(15, 0)), tid, now_t);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_INSERT;
    in_ch.deadline     = '0;
    in_ch.priority_req = '0;
    in_ch.target_id    = '0;
    in_ch.now_time     = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_EXPIRY_WINDOW;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;
    time_base          = 32'd10000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, register defaults from reset
    send_req(FUNC_CHECK, '0, '0, '0, '1);
    send_req(FUNC_REMOVE, '0, '0, '0, '0);
    send_req(FUNC_UNUSED, '1, '1, '1, '1);
    send_req(FUNC_INSERT, 32'd1000, 4'd0, '0, '0);
    send_req(FUNC_INSERT, 32'd1000, 4'd15, '0, '0);
    send_req(FUNC_INSERT, 32'd0, 4'd5, '0, '0);
    send_req(FUNC_INSERT, '1, 4'd15, '0, '0);
    send_req(FUNC_CHECK, '0, '0, '0, 32'd0);
    send_req(FUNC_CHECK, '0, '0, '0, 32'd999);
    // equal deadlines: the newer one comes out first; lateness equal to the window executes
    send_req(FUNC_CHECK, '0, '0, '0, 32'd2800);
    send_req(FUNC_CHECK, '0, '0, '0, 32'd2800);
    send_req(FUNC_INSERT, 32'd500, 4'd9, '0, '0);
    send_req(FUNC_CHECK, '0, '0, '0, 32'd2301);
    send_req(FUNC_INSERT, 32'd500, 4'd10, '0, '0);
    send_req(FUNC_CHECK, '0, '0, '0, 32'd2301);
    send_req(FUNC_INSERT, 32'd7, 4'd3, '0, '0);
    send_req(FUNC_REMOVE, '0, '0, 32'd6, '0);
    send_req(FUNC_REMOVE, '0, '0, 32'd6, '0);
    send_req(FUNC_REMOVE, '0, '0, '1, '0);
    send_req(FUNC_CHECK, '0, '0, '0, '1);
    send_req(FUNC_CHECK, '0, '0, '0, '1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          win_val = EXPIRY_WINDOW_RST; exm_val = EXEMPT_PRIORITY_RST;
          send_idle = 0; recv_stall <= 0;
        end
        1: begin
          win_val = '0; exm_val = '0;
          send_idle = 53; recv_stall <= 0;
        end
        2: begin
          win_val = '1; exm_val = '1;
          send_idle = 0; recv_stall <= 53;
        end
        3: begin
          win_val = 32'd50; exm_val = '1;
          send_idle = 34; recv_stall <= 34;
        end
        4: begin
          win_val = EXPIRY_WINDOW_RST; exm_val = PR_W'($urandom_range(15, 0));
          send_idle = 0; recv_stall <= 0;
        end
        default: begin
          win_val = $urandom_range(3000, 0); exm_val = PR_W'($urandom_range(15, 0));
          send_idle = 34; recv_stall <= 34;
        end
      endcase
      set_regs(win_val, exm_val);
      // empty the queue so stale far-future entries do not pile up
      for (k = 0; k <= DEPTH; k++) begin
        send_req(FUNC_CHECK, $urandom(), PR_W'($urandom()), $urandom(), '1);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 4 && k == 10) hold_asked <= hold_asked + 1;
        if (ph == 4 && k == 70) settle();
        ins_pct = ((k / 20) % 2 == 0) ? 60 : 22;
        random_req(ins_pct);
      end
    end

    settle();
    $display("run: %0d requests over %0d register settings, %0d executed, %0d discarded",
             n_requests, NUM_PHASES + 1, n_executed, n_discarded);
    $display("run: %0d full-queue refusals, %0d unknown ids, %0d checks with nothing due",
             n_refused, n_unknown, n_none_due);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
